>>> rtl/core/rba_pkg.sv
// Shared types and constants for the bitmap run allocator.
// Used by rba_run_unit, rba_usage_mem and bitmap_run_allocator_core.
package rba_pkg;

    // Default number of map bytes held in storage
    localparam int unsigned MAP_BYTES_DEF = 512;

    // Fixed field widths
    localparam int unsigned IDX_W = 32;
    localparam int unsigned CNT_W = 13;
    localparam int unsigned MAPB_W = 10;
    localparam int unsigned CFG_IDX_W = 1;

    // Operation codes
    localparam logic [1:0] OP_TEST  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_SCAN  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INDEX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_BYTES  = 1'b1;

    // Request payload
    typedef struct packed {
        logic [1:0]       operation;
        logic [IDX_W-1:0] index;
        logic             value;
        logic [CNT_W-1:0] count;
    } req_t;

    // Response payload
    typedef struct packed {
        logic             bit_value;
        logic             found;
        logic [IDX_W-1:0] start_index;
        logic             error;
    } rsp_t;

    // Result of one byte pass through the run counter
    typedef struct packed {
        logic             hit;
        logic [2:0]       hit_bit;
        logic [CNT_W-1:0] run;
    } run_res_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_APPLY,
        ST_SCAN,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/core/rba_run_unit.sv
// Free-run counter applied to one map byte, bit 0 first.
// Depends on rba_pkg for the count width and the result struct.
module rba_run_unit (
    input  logic [7:0]              flags,
    input  logic [rba_pkg::CNT_W-1:0] run_in,
    input  logic [rba_pkg::CNT_W-1:0] count,
    output rba_pkg::run_res_t       res
);
    import rba_pkg::*;

    logic [CNT_W-1:0] run;
    logic             hit;
    logic [2:0]       hit_bit;

    // Walk the eight flags; first position where the run reaches count wins
    always_comb
    begin
        run     = run_in;
        hit     = 1'b0;
        hit_bit = 3'd0;
        for (int b = 0; b < 8; b++)
        begin
            if (flags[b])
                run = '0;
            else
                run = run + CNT_W'(1);
            if (!hit && (run == count))
            begin
                hit     = 1'b1;
                hit_bit = 3'(b);
            end
        end
    end

    assign res.hit     = hit;
    assign res.hit_bit = hit_bit;
    assign res.run     = run;

endmodule

>>> rtl/core/rba_usage_mem.sv
// Usage byte store: one write port, one read port with registered data.
// Depends on rba_pkg only for its default depth.
module rba_usage_mem #(
    parameter int unsigned DEPTH = rba_pkg::MAP_BYTES_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    import rba_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/bitmap_run_allocator_core.sv
// Top level of the bitmap run allocator: sequencer, config and result register.
// Depends on rba_pkg, rba_usage_mem and rba_run_unit.
//
//   Channel  Signals                          Direction  Carries
//   in       in_valid / in_stall / in_data    in         request (req_t)
//   out      out_valid / out_stall / out_data out        response (rsp_t)
//   cfg      cfg_wr_en / cfg_index / cfg_data in         register write
//
// After reset a clearing pass zeroes every map byte, with in_stall high.
// Test and write: after accept the request passes lookup, apply and finish before the
// response is valid; a rejected request goes from lookup straight to finish.
// Scan: map bytes are read in order up to the end of the run, then each run byte is
// marked by a read and a write (single memory read port); a miss reads all live bytes.
// One request in flight; in_stall drops the cycle after the response is registered,
// and the output register holds it while out_stall is high.
module bitmap_run_allocator_core #(
    parameter int unsigned MAP_BYTES = rba_pkg::MAP_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  rba_pkg::req_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output rba_pkg::rsp_t                 out_data,
    input  logic                          cfg_wr_en,
    input  logic [rba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rba_pkg::IDX_W-1:0]     cfg_data
);
    import rba_pkg::*;

    localparam int unsigned AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int unsigned LW = $clog2(MAP_BYTES + 1);
    localparam int unsigned MW = (LW > MAPB_W) ? LW : MAPB_W;
    localparam int unsigned PW = AW + 3;
    localparam int unsigned FW = ((PW > CNT_W) ? PW : CNT_W) + 1;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  base_reg;
    logic [MAPB_W-1:0] map_bytes_reg;

    req_t req_reg, req_next;
    rsp_t res_reg, res_next;
    rsp_t out_data_reg;
    logic out_valid_reg, out_valid_next;

    logic [AW-1:0]    clr_ptr_reg, clr_ptr_next;
    logic [LW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]    proc_ptr_reg, proc_ptr_next;
    logic             proc_vld_reg, proc_vld_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [PW-1:0]    first_reg, first_next;
    logic [PW-1:0]    end_reg, end_next;
    logic [AW-1:0]    mk_ptr_reg, mk_ptr_next;
    logic [AW-1:0]    byte_addr_reg, byte_addr_next;
    logic [2:0]       bit_sel_reg, bit_sel_next;

    logic [LW-1:0]    live;
    logic [MW-1:0]    live_ext;
    logic [IDX_W:0]   rel_w;
    logic [IDX_W-1:0] rel;
    logic             loc_err;
    logic             out_free;
    logic             scan_done;
    logic             mark_last;
    logic [PW-1:0]    end_pos;
    logic [FW-1:0]    first_w;
    logic [2:0]       mk_lo, mk_hi;
    logic [7:0]       mk_mask;
    logic [7:0]       bit_mask;

    logic          mem_wr_en, mem_rd_en;
    logic [AW-1:0] mem_wr_addr, mem_rd_addr;
    logic [7:0]    mem_wr_data, mem_rd_data;
    run_res_t      ru;

    rba_usage_mem #(
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rba_run_unit u_run (
        .flags  (mem_rd_data),
        .run_in (run_reg),
        .count  (req_reg.count),
        .res    (ru)
    );

    // Bytes in use, saturated at storage depth
    assign live_ext = MW'(map_bytes_reg);
    assign live     = (live_ext > MW'(MAP_BYTES)) ? LW'(MAP_BYTES) : live_ext[LW-1:0];

    // Index translation; borrow means below base
    assign rel_w   = {1'b0, req_reg.index} - {1'b0, base_reg};
    assign rel     = rel_w[IDX_W-1:0];
    assign loc_err = rel_w[IDX_W] || (rel[IDX_W-1:3] >= (IDX_W-3)'(live));

    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_done = !proc_vld_reg && (rd_ptr_reg == live);
    assign mark_last = (mk_ptr_reg == end_reg[PW-1:3]);

    // Run end and start positions
    assign end_pos = {proc_ptr_reg, ru.hit_bit};
    assign first_w = FW'(end_pos) + FW'(1) - FW'(req_reg.count);

    // Mask of run bits inside the byte being marked
    assign mk_lo   = (mk_ptr_reg == first_reg[PW-1:3]) ? first_reg[2:0] : 3'd0;
    assign mk_hi   = mark_last ? end_reg[2:0] : 3'd7;
    assign mk_mask = (8'hFF << mk_lo) & (8'hFF >> (3'd7 - mk_hi));

    assign bit_mask = 8'h01 << bit_sel_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            map_bytes_reg <= MAPB_W'(512);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BASE_INDEX: base_reg      <= cfg_data;
                CFG_MAP_BYTES:  map_bytes_reg <= cfg_data[MAPB_W-1:0];
                default:        ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_ptr_reg == AW'(MAP_BYTES - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_valid)
                    state_next = ST_LOOKUP;
            ST_LOOKUP:
            begin
                case (req_reg.operation)
                    OP_TEST, OP_WRITE:
                        state_next = loc_err ? ST_FINISH : ST_APPLY;
                    OP_SCAN:
                        state_next = (req_reg.count == '0) ? ST_FINISH : ST_SCAN;
                    default:
                        state_next = ST_FINISH;
                endcase
            end
            ST_APPLY:
                state_next = ST_FINISH;
            ST_SCAN:
            begin
                if (proc_vld_reg && ru.hit)
                    state_next = ST_MARK_RD;
                else if (scan_done)
                    state_next = ST_FINISH;
            end
            ST_MARK_RD:
                state_next = ST_MARK_WR;
            ST_MARK_WR:
                state_next = mark_last ? ST_FINISH : ST_MARK_RD;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    // Memory controls and input stall
    always_comb
    begin
        in_stall    = 1'b1;
        mem_wr_en   = 1'b0;
        mem_wr_addr = mk_ptr_reg;
        mem_wr_data = mem_rd_data | mk_mask;
        mem_rd_en   = 1'b0;
        mem_rd_addr = mk_ptr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_ptr_reg;
                mem_wr_data = 8'h00;
            end
            ST_IDLE:
                in_stall = 1'b0;
            ST_LOOKUP:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = rel[AW+2:3];
            end
            ST_APPLY:
            begin
                mem_wr_en   = (req_reg.operation == OP_WRITE);
                mem_wr_addr = byte_addr_reg;
                mem_wr_data = req_reg.value ? (mem_rd_data | bit_mask)
                                            : (mem_rd_data & ~bit_mask);
            end
            ST_SCAN:
            begin
                mem_rd_en   = (rd_ptr_reg < live);
                mem_rd_addr = rd_ptr_reg[AW-1:0];
            end
            ST_MARK_RD:
                mem_rd_en = 1'b1;
            ST_MARK_WR:
                mem_wr_en = 1'b1;
            default:
                ;
        endcase
    end

    // Datapath registers
    always_comb
    begin
        req_next       = req_reg;
        res_next       = res_reg;
        clr_ptr_next   = clr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        proc_ptr_next  = proc_ptr_reg;
        proc_vld_next  = proc_vld_reg;
        run_next       = run_reg;
        first_next     = first_reg;
        end_next       = end_reg;
        mk_ptr_next    = mk_ptr_reg;
        byte_addr_next = byte_addr_reg;
        bit_sel_next   = bit_sel_reg;
        case (state_reg)
            ST_CLEAR:
                clr_ptr_next = clr_ptr_reg + AW'(1);
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = in_data;
                    res_next = '0;
                end
            end
            ST_LOOKUP:
            begin
                byte_addr_next = rel[AW+2:3];
                bit_sel_next   = rel[2:0];
                rd_ptr_next    = '0;
                proc_vld_next  = 1'b0;
                run_next       = '0;
                case (req_reg.operation)
                    OP_TEST, OP_WRITE:
                        res_next.error = loc_err;
                    OP_SCAN:
                        res_next.error = (req_reg.count == '0);
                    default:
                        res_next.error = 1'b1;
                endcase
            end
            ST_APPLY:
                if (req_reg.operation == OP_TEST)
                    res_next.bit_value = |(mem_rd_data & bit_mask);
            ST_SCAN:
            begin
                // Issue the next byte read while the previous byte is counted
                proc_vld_next = (rd_ptr_reg < live);
                proc_ptr_next = rd_ptr_reg[AW-1:0];
                if (rd_ptr_reg < live)
                    rd_ptr_next = rd_ptr_reg + LW'(1);
                if (proc_vld_reg)
                begin
                    run_next = ru.run;
                    if (ru.hit)
                    begin
                        end_next    = end_pos;
                        first_next  = first_w[PW-1:0];
                        mk_ptr_next = first_w[PW-1:3];
                    end
                end
            end
            ST_MARK_WR:
            begin
                if (mark_last)
                begin
                    res_next.found       = 1'b1;
                    res_next.start_index = base_reg + IDX_W'(first_reg);
                end
                else
                    mk_ptr_next = mk_ptr_reg + AW'(1);
            end
            default:
                ;
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if ((state_reg == ST_FINISH) && out_free)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            clr_ptr_reg   <= '0;
            rd_ptr_reg    <= '0;
            proc_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            clr_ptr_reg   <= clr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            proc_vld_reg  <= proc_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        res_reg       <= res_next;
        proc_ptr_reg  <= proc_ptr_next;
        run_reg       <= run_next;
        first_reg     <= first_next;
        end_reg       <= end_next;
        mk_ptr_reg    <= mk_ptr_next;
        byte_addr_reg <= byte_addr_next;
        bit_sel_reg   <= bit_sel_next;
        if ((state_reg == ST_FINISH) && out_free)
            out_data_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A pending response is never overwritten by the one behind it
    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && out_valid_reg && out_stall |=> (state_reg == ST_FINISH))
        else $error("finished response dropped while output stalled");

    // Scan read pointer never passes the end of the live map
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rd_ptr_reg <= live))
        else $error("scan pointer past live map");

    // Marking walk stays between the run's first and last byte
    a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MARK_RD) || (state_reg == ST_MARK_WR)) |->
        ((mk_ptr_reg >= first_reg[PW-1:3]) && (mk_ptr_reg <= end_reg[PW-1:3])))
        else $error("mark pointer outside allocated run");

    // Map is never written while waiting for a request
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_wr_en)
        else $error("map written while idle");

    // A found run is never reported together with an error
    a_found_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.found && out_data_reg.error))
        else $error("response flags found and error together");

endmodule

>>> dv/bitmap_run_allocator_core_test.sv
// Self-checking testbench for bitmap_run_allocator_core: test, write and scan requests
// over several base/map-size settings, checked against a behavioral allocator model.
// Depends on rba_pkg and the bitmap_run_allocator_core RTL.
module bitmap_run_allocator_core_test;

    import rba_pkg::*;

    // Operation code the block does not define; must be rejected
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned MAP_BITS = MAP_BYTES_DEF * 8;
    localparam int unsigned BIT_W = $clog2(MAP_BITS);
    localparam int unsigned PHASE_ITEMS = 60;
    localparam int unsigned RANDOM_PHASES = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    req_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    rsp_t out_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [IDX_W-1:0] cfg_data = '0;

    // Model state: flags, shadow registers
    bit used_flags [0:MAP_BITS-1];
    logic [IDX_W-1:0] model_base = '0;
    logic [MAPB_W-1:0] model_map_bytes = 10'd512;

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];

    bit no_idle = 1'b0;
    int unsigned req_gap = 0;
    int unsigned stall_left = 0;

    int unsigned mismatch_count = 0;
    int unsigned rsp_seen = 0;
    int unsigned n_test = 0;
    int unsigned n_write = 0;
    int unsigned n_scan = 0;
    int unsigned n_found = 0;
    int unsigned n_rejected = 0;
    int unsigned n_settings = 0;

    bitmap_run_allocator_core #(
        .MAP_BYTES(MAP_BYTES_DEF)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock and reset
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Number of live map bits, map size saturated to storage
    function automatic int unsigned live_bit_count();
        return ((model_map_bytes > MAP_BYTES_DEF) ? MAP_BYTES_DEF : model_map_bytes) * 8;
    endfunction

    // Expected response for one request; updates the flag model
    function automatic rsp_t alloc_predict(req_t r);
        rsp_t res;
        int unsigned live_bits;
        logic [IDX_W-1:0] rel;
        int unsigned run;
        int unsigned p;
        int unsigned first;
        bit hit;
        res = '0;
        live_bits = live_bit_count();
        rel = r.index - model_base;
        run = 0;
        hit = 1'b0;
        case (r.operation)
            OP_TEST:
            begin
                n_test++;
                if (r.index < model_base || rel >= live_bits)
                    res.error = 1'b1;
                else
                    res.bit_value = used_flags[rel[BIT_W-1:0]];
            end
            OP_WRITE:
            begin
                n_write++;
                if (r.index < model_base || rel >= live_bits)
                    res.error = 1'b1;
                else
                    used_flags[rel[BIT_W-1:0]] = r.value;
            end
            OP_SCAN:
            begin
                n_scan++;
                if (r.count == 0)
                begin
                    res.error = 1'b1;
                end
                else
                begin
                    // first fit from the bottom
                    for (p = 0; p < live_bits; p++)
                    begin
                        run = used_flags[p] ? 0 : run + 1;
                        if (run == r.count)
                        begin
                            hit = 1'b1;
                            break;
                        end
                    end
                    if (hit)
                    begin
                        first = p + 1 - r.count;
                        for (int unsigned i = first; i <= p; i++)
                            used_flags[i] = 1'b1;
                        res.found = 1'b1;
                        res.start_index = model_base + first;
                        n_found++;
                    end
                end
            end
            default:
                res.error = 1'b1;
        endcase
        if (res.error)
            n_rejected++;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [IDX_W-1:0] got, logic [IDX_W-1:0] want);
        $display("mismatch on response %0d: %s got %h expected %h",
                 rsp_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_rsp(rsp_t got);
        rsp_t want;
        rsp_seen++;
        if (expected_rsps.size() == 0)
        begin
            report_mismatch("response with no request pending", got.start_index, '0);
            return;
        end
        want = expected_rsps.pop_front();
        if (got.bit_value !== want.bit_value)
            report_mismatch("bit_value", IDX_W'(got.bit_value), IDX_W'(want.bit_value));
        if (got.found !== want.found)
            report_mismatch("found", IDX_W'(got.found), IDX_W'(want.found));
        if (got.start_index !== want.start_index)
            report_mismatch("start_index", got.start_index, want.start_index);
        if (got.error !== want.error)
            report_mismatch("error", IDX_W'(got.error), IDX_W'(want.error));
    endtask

    // Request driver: random gap after each accepted request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            req_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_rsps.push_back(alloc_predict(in_data));
            if (!in_valid || !in_stall)
            begin
                if (req_gap != 0)
                begin
                    req_gap <= req_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    in_data <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    req_gap <= no_idle ? 0 : $urandom_range(0, 10);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: random stall after each accepted response
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        int unsigned hold;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            check_rsp(out_data);
            hold = no_idle ? 0 : $urandom_range(0, 10);
            stall_left <= hold;
            out_stall <= (hold != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end
    end

    function automatic void push_req(logic [1:0] op, logic [IDX_W-1:0] idx, logic val,
                                     logic [CNT_W-1:0] cnt);
        req_t r;
        r.operation = op;
        r.index = idx;
        r.value = val;
        r.count = cnt;
        pending_reqs.push_back(r);
    endfunction

    // Random request, mostly in range, some out of range or malformed
    function automatic req_t random_req();
        req_t r;
        int unsigned live_bits;
        int unsigned op_pick;
        live_bits = live_bit_count();
        op_pick = $urandom_range(0, 19);
        if (op_pick < 6)
            r.operation = OP_TEST;
        else if (op_pick < 12)
            r.operation = OP_WRITE;
        else if (op_pick < 19)
            r.operation = OP_SCAN;
        else
            r.operation = OP_UNUSED;
        case ($urandom_range(0, 9))
            0: r.index = $urandom();
            1: r.index = model_base - $urandom_range(1, 16);
            2: r.index = model_base + live_bits + $urandom_range(0, 16);
            default:
                r.index = model_base +
                          ((live_bits != 0) ? $urandom_range(0, live_bits - 1) : 0);
        endcase
        // lean toward freeing so the map does not fill up
        r.value = ($urandom_range(0, 9) < 4);
        case ($urandom_range(0, 9))
            0: r.count = '0;
            1: r.count = CNT_W'($urandom_range(0, 8191));
            2: r.count = CNT_W'(live_bits + $urandom_range(0, 8));
            default: r.count = CNT_W'($urandom_range(1, 12));
        endcase
        return r;
    endfunction

    // Wait until no request is queued, in flight or awaiting its response
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [IDX_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_BASE_INDEX)
            model_base = data;
        else
            model_map_bytes = data[MAPB_W-1:0];
    endtask

    task automatic set_config(logic [IDX_W-1:0] base, logic [MAPB_W-1:0] map_size);
        wait_drained();
        cfg_write(CFG_BASE_INDEX, base);
        cfg_write(CFG_MAP_BYTES, {{(IDX_W - MAPB_W){1'b0}}, map_size});
        n_settings++;
    endtask

    // Stimulus: directed cases, then random phases under random settings
    initial
    begin
        logic [IDX_W-1:0] b;
        logic [MAPB_W-1:0] mb;
        @(posedge rst_n);

        // Full map, base away from zero
        set_config(32'h0000_1000, 10'd512);
        b = model_base;
        push_req(OP_TEST, b, 1'b0, 13'h1FFF);
        push_req(OP_TEST, b - 1, 1'b0, 13'd0);
        push_req(OP_TEST, b + MAP_BITS - 1, 1'b0, 13'd0);
        push_req(OP_TEST, b + MAP_BITS, 1'b0, 13'd0);
        push_req(OP_TEST, 32'hFFFF_FFFF, 1'b0, 13'd0);
        push_req(OP_WRITE, b + MAP_BITS - 1, 1'b1, 13'd0);
        push_req(OP_TEST, b + MAP_BITS - 1, 1'b0, 13'd0);
        push_req(OP_WRITE, b + MAP_BITS, 1'b1, 13'd0);
        push_req(OP_SCAN, b, 1'b0, 13'd0);
        push_req(OP_SCAN, b, 1'b0, 13'd1);
        push_req(OP_SCAN, b, 1'b0, 13'd3);
        push_req(OP_WRITE, b + 2, 1'b0, 13'd0);
        push_req(OP_TEST, b + 2, 1'b0, 13'd0);
        push_req(OP_SCAN, b, 1'b0, 13'd2);
        push_req(OP_SCAN, b, 1'b0, 13'd4096);
        push_req(OP_SCAN, b, 1'b0, 13'h1FFF);
        push_req(OP_UNUSED, b, 1'b1, 13'd5);
        push_req(OP_SCAN, 32'hFFFF_FFFF, 1'b1, 13'd1);

        // Top base, oversized map register: start index wraps
        set_config(32'hFFFF_FFFF, 10'd1023);
        push_req(OP_TEST, 32'hFFFF_FFFF, 1'b0, 13'd0);
        push_req(OP_TEST, 32'h0000_0000, 1'b0, 13'd0);
        push_req(OP_WRITE, 32'hFFFF_FFFF, 1'b0, 13'd0);
        push_req(OP_SCAN, 32'h0000_0000, 1'b0, 13'd4);

        // Empty map
        set_config(32'hFFFF_FFF0, 10'd0);
        push_req(OP_TEST, 32'hFFFF_FFF0, 1'b0, 13'd0);
        push_req(OP_SCAN, 32'hFFFF_FFF0, 1'b0, 13'd1);

        // One-byte map at zero
        set_config(32'h0000_0000, 10'd1);
        push_req(OP_TEST, 32'd7, 1'b0, 13'd0);
        push_req(OP_TEST, 32'd8, 1'b0, 13'd0);
        push_req(OP_SCAN, 32'd0, 1'b0, 13'd9);

        // Random phases; every fourth one with no idling on either side
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 9))
                0: mb = '0;
                1: mb = MAPB_W'($urandom_range(513, 1023));
                2: mb = MAPB_W'($urandom_range(17, 512));
                default: mb = MAPB_W'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 3))
                0: b = '0;
                1: b = 32'hFFFF_FFFF - $urandom_range(0, 4095);
                default: b = $urandom();
            endcase
            set_config(b, mb);
            no_idle = (ph % 4 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_reqs.push_back(random_req());
        end

        // Drain and let any stray response show up
        wait_drained();
        repeat (20) @(posedge clk);
        if (expected_rsps.size() != 0)
            report_mismatch("responses never returned", IDX_W'(expected_rsps.size()), '0);
        $display("ran %0d test, %0d write and %0d scan requests under %0d map settings",
                 n_test, n_write, n_scan, n_settings);
        $display("%0d runs allocated, %0d requests rejected, %0d mismatches",
                 n_found, n_rejected, mismatch_count);
        if (mismatch_count == 0)
            $display("bitmap_run_allocator_core_test: PASS");
        else
            $display("bitmap_run_allocator_core_test: FAIL");
        $finish;
    end

    // Run limit
    initial
    begin
        #100_000_000;
        $display("timeout with %0d requests queued, %0d responses outstanding",
                 pending_reqs.size(), expected_rsps.size());
        $display("bitmap_run_allocator_core_test: FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/rba_pkg.sv
rtl/core/rba_run_unit.sv
rtl/core/rba_usage_mem.sv
rtl/core/bitmap_run_allocator_core.sv
dv/bitmap_run_allocator_core_test.sv
